// ----- hw/rtl/typed_column_record_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// typed_column_record_decoder_defines.svh
// assertion macros shared by the checker of the record decoder
// ----------------------------------------------------------------------------
`ifndef TYPED_COLUMN_RECORD_DECODER_DEFINES_SVH
`define TYPED_COLUMN_RECORD_DECODER_DEFINES_SVH

// same-cycle implication, off during reset
`define TCRD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, off during reset
`define TCRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- hw/rtl/tcrd_pkg.sv -----
// ----------------------------------------------------------------------------
// tcrd_pkg
// types and codes of the typed column record decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcrd_pkg;

  localparam int PAYLOAD_LENGTH_BITS_DEF = 31;
  localparam int QUEUE_DEPTH             = 4;
  localparam int QUEUE_PTR_BITS          = $clog2(QUEUE_DEPTH);

  // tag types
  localparam logic [2:0] TYPE_INTEGER = 3'd1;
  localparam logic [2:0] TYPE_FLOAT   = 3'd2;
  localparam logic [2:0] TYPE_TEXT    = 3'd3;
  localparam logic [2:0] TYPE_BLOB    = 3'd4;
  localparam logic [2:0] TYPE_NULL    = 3'd5;

  localparam logic [3:0] FLOAT_BYTES = 4'd8;

  // result kinds
  localparam logic [2:0] KIND_NULL     = 3'd0;
  localparam logic [2:0] KIND_INTEGER  = 3'd1;
  localparam logic [2:0] KIND_FLOAT    = 3'd2;
  localparam logic [2:0] KIND_BLOB_LEN = 3'd3;
  localparam logic [2:0] KIND_TEXT_LEN = 3'd4;
  localparam logic [2:0] KIND_PAYLOAD  = 3'd5;
  localparam logic [2:0] KIND_END      = 3'd6;
  localparam logic [2:0] KIND_ERROR    = 3'd7;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN   = 2'd2;
  localparam logic [1:0] ERR_OVERSIZE  = 2'd3;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TAG,
    PH_FIELD,
    PH_PAYLOAD,
    PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_FAIL,
    ACT_END_ONLY,
    ACT_COL_END,
    ACT_LENGTH,
    ACT_PAYLOAD
  } act_t;

  // one classified input byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [2:0] tag_type;
    logic [4:0] tag_count;
    logic       byte_zero;
    logic       count_zero;
    logic       count_gt4;
    logic       count_gt8;
  } entry_t;

endpackage

// ----- hw/rtl/tcrd_front.sv -----
// ----------------------------------------------------------------------------
// tcrd_front
// accepts record bytes and classifies them for the parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcrd_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic              q_full,
  output logic              q_push,
  output tcrd_pkg::entry_t  q_entry
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_entry            = '0;
    q_entry.data       = data_byte;
    q_entry.last       = last_byte;
    q_entry.tag_type   = data_byte[2:0];
    q_entry.tag_count  = data_byte[7:3];
    q_entry.byte_zero  = (data_byte == 8'd0);
    q_entry.count_zero = (data_byte[7:3] == 5'd0);
    q_entry.count_gt4  = (data_byte[7:3] > 5'd4);
    q_entry.count_gt8  = (data_byte[7:3] > 5'd8);
  end

endmodule

// ----- hw/rtl/tcrd_queue.sv -----
// ----------------------------------------------------------------------------
// tcrd_queue
// short register queue between the classifier and the parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcrd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tcrd_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output tcrd_pkg::entry_t  head_entry
);

  tcrd_pkg::entry_t                     slots [tcrd_pkg::QUEUE_DEPTH];
  logic [tcrd_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr;
  logic [tcrd_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr;
  logic [tcrd_pkg::QUEUE_PTR_BITS:0]    fill;

  assign full       = (fill == (tcrd_pkg::QUEUE_PTR_BITS+1)'(tcrd_pkg::QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/tcrd_back.sv -----
// ----------------------------------------------------------------------------
// tcrd_back
// record parser: walks header, tags, fields and payload, registers results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcrd_back #(
  parameter int PAYLOAD_LENGTH_BITS = tcrd_pkg::PAYLOAD_LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  tcrd_pkg::entry_t  q_entry,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        kind,
  output logic [7:0]        column_index,
  output logic [63:0]       value_bits,
  output logic [7:0]        payload_value,
  output logic              record_done,
  output logic [1:0]        error_code,
  output logic [7:0]        column_count
);

  tcrd_pkg::phase_t                phase, phase_next;
  logic [7:0]                      columns_total, columns_total_next;
  logic [7:0]                      current_column, current_column_next;
  logic [2:0]                      current_type, current_type_next;
  logic [3:0]                      field_bytes_left, field_bytes_left_next;
  logic [2:0]                      byte_position, byte_position_next;
  logic [63:0]                     value_accumulator, value_accumulator_next;
  logic [PAYLOAD_LENGTH_BITS-1:0]  payload_bytes_left, payload_bytes_left_next;

  tcrd_pkg::act_t   act;
  logic [1:0]       act_err;
  logic [2:0]       col_kind;
  logic [63:0]      col_value;
  logic [63:0]      len_value;
  logic             col_end_req;
  logic             len_done_req;
  logic             final_col;
  logic [2:0]       type_eff;
  logic [2:0]       len_kind;
  logic [63:0]      acc_new;
  logic [3:0]       fbl_dec;
  logic [PAYLOAD_LENGTH_BITS-1:0] pbl_dec;
  logic [7:0]       b;
  logic             last;

  logic [2:0]       res_kind;
  logic [7:0]       res_column;
  logic [63:0]      res_value;
  logic [7:0]       res_payload;
  logic             res_done;
  logic [1:0]       res_err;
  logic [7:0]       res_count;

  assign q_pop = q_valid && (!out_valid || out_ready);
  assign b     = q_entry.data;
  assign last  = q_entry.last;

  assign final_col = ({1'b0, current_column} + 9'd1) >= {1'b0, columns_total};
  assign type_eff  = (phase == tcrd_pkg::PH_TAG) ? q_entry.tag_type : current_type;
  assign len_kind  = (type_eff == tcrd_pkg::TYPE_BLOB) ? tcrd_pkg::KIND_BLOB_LEN
                                                       : tcrd_pkg::KIND_TEXT_LEN;
  assign acc_new   = value_accumulator | ({56'd0, b} << {byte_position, 3'b000});
  assign fbl_dec   = field_bytes_left - 4'd1;
  assign pbl_dec   = payload_bytes_left - PAYLOAD_LENGTH_BITS'(1);

  // decide what this byte does
  always_comb begin
    act          = tcrd_pkg::ACT_NONE;
    act_err      = tcrd_pkg::ERR_NONE;
    col_kind     = tcrd_pkg::KIND_NULL;
    col_value    = '0;
    len_value    = '0;
    col_end_req  = 1'b0;
    len_done_req = 1'b0;
    unique case (phase)
      tcrd_pkg::PH_HEADER: begin
        if (q_entry.byte_zero) begin
          act = tcrd_pkg::ACT_END_ONLY;
        end else if (last) begin
          act     = tcrd_pkg::ACT_FAIL;
          act_err = tcrd_pkg::ERR_TRUNCATED;
        end
      end
      tcrd_pkg::PH_TAG: begin
        unique case (q_entry.tag_type) inside
          tcrd_pkg::TYPE_NULL: begin
            col_end_req = 1'b1;
            col_kind    = tcrd_pkg::KIND_NULL;
          end
          tcrd_pkg::TYPE_INTEGER: begin
            if (q_entry.count_gt8) begin
              act     = tcrd_pkg::ACT_FAIL;
              act_err = tcrd_pkg::ERR_OVERSIZE;
            end else if (q_entry.count_zero) begin
              col_end_req = 1'b1;
              col_kind    = tcrd_pkg::KIND_INTEGER;
            end else if (last) begin
              act     = tcrd_pkg::ACT_FAIL;
              act_err = tcrd_pkg::ERR_TRUNCATED;
            end
          end
          tcrd_pkg::TYPE_FLOAT: begin
            if (last) begin
              act     = tcrd_pkg::ACT_FAIL;
              act_err = tcrd_pkg::ERR_TRUNCATED;
            end
          end
          tcrd_pkg::TYPE_BLOB, tcrd_pkg::TYPE_TEXT: begin
            if (q_entry.count_gt4) begin
              act     = tcrd_pkg::ACT_FAIL;
              act_err = tcrd_pkg::ERR_OVERSIZE;
            end else if (q_entry.count_zero) begin
              len_done_req = 1'b1;
            end else if (last) begin
              act     = tcrd_pkg::ACT_FAIL;
              act_err = tcrd_pkg::ERR_TRUNCATED;
            end
          end
          default: begin
            act     = tcrd_pkg::ACT_FAIL;
            act_err = tcrd_pkg::ERR_UNKNOWN;
          end
        endcase
      end
      tcrd_pkg::PH_FIELD: begin
        if (fbl_dec != 4'd0) begin
          if (last) begin
            act     = tcrd_pkg::ACT_FAIL;
            act_err = tcrd_pkg::ERR_TRUNCATED;
          end
        end else if (current_type == tcrd_pkg::TYPE_BLOB ||
                     current_type == tcrd_pkg::TYPE_TEXT) begin
          len_done_req = 1'b1;
          len_value    = acc_new;
        end else begin
          col_end_req = 1'b1;
          col_value   = acc_new;
          col_kind    = (current_type == tcrd_pkg::TYPE_FLOAT) ? tcrd_pkg::KIND_FLOAT
                                                               : tcrd_pkg::KIND_INTEGER;
        end
      end
      tcrd_pkg::PH_PAYLOAD: begin
        if (pbl_dec != '0) begin
          if (last) begin
            act     = tcrd_pkg::ACT_FAIL;
            act_err = tcrd_pkg::ERR_TRUNCATED;
          end else begin
            act = tcrd_pkg::ACT_PAYLOAD;
          end
        end else begin
          col_end_req = 1'b1;
          col_kind    = tcrd_pkg::KIND_PAYLOAD;
        end
      end
      default: begin
        act = tcrd_pkg::ACT_NONE;
      end
    endcase

    // length field complete
    if (len_done_req) begin
      if ((len_value >> PAYLOAD_LENGTH_BITS) != 64'd0) begin
        act     = tcrd_pkg::ACT_FAIL;
        act_err = tcrd_pkg::ERR_OVERSIZE;
      end else if (len_value == 64'd0) begin
        col_end_req = 1'b1;
        col_kind    = len_kind;
        col_value   = '0;
      end else if (last) begin
        act     = tcrd_pkg::ACT_FAIL;
        act_err = tcrd_pkg::ERR_TRUNCATED;
      end else begin
        act = tcrd_pkg::ACT_LENGTH;
      end
    end

    // column complete; ending early on a non-final column is truncation
    if (col_end_req) begin
      if (!final_col && last) begin
        act     = tcrd_pkg::ACT_FAIL;
        act_err = tcrd_pkg::ERR_TRUNCATED;
      end else begin
        act = tcrd_pkg::ACT_COL_END;
      end
    end
  end

  // next state
  always_comb begin
    phase_next              = phase;
    columns_total_next      = columns_total;
    current_column_next     = current_column;
    current_type_next       = current_type;
    field_bytes_left_next   = field_bytes_left;
    byte_position_next      = byte_position;
    value_accumulator_next  = value_accumulator;
    payload_bytes_left_next = payload_bytes_left;
    unique case (phase)
      tcrd_pkg::PH_HEADER: begin
        columns_total_next  = b;
        current_column_next = '0;
        if (act == tcrd_pkg::ACT_NONE) begin
          phase_next = tcrd_pkg::PH_TAG;
        end
      end
      tcrd_pkg::PH_TAG: begin
        current_type_next      = q_entry.tag_type;
        field_bytes_left_next  = (q_entry.tag_type == tcrd_pkg::TYPE_FLOAT)
                                 ? tcrd_pkg::FLOAT_BYTES : q_entry.tag_count[3:0];
        byte_position_next     = '0;
        value_accumulator_next = '0;
        if (act == tcrd_pkg::ACT_NONE) begin
          phase_next = tcrd_pkg::PH_FIELD;
        end
      end
      tcrd_pkg::PH_FIELD: begin
        value_accumulator_next = acc_new;
        byte_position_next     = byte_position + 3'd1;
        field_bytes_left_next  = fbl_dec;
      end
      tcrd_pkg::PH_PAYLOAD: begin
        payload_bytes_left_next = pbl_dec;
      end
      default: begin
        if (last) begin
          phase_next = tcrd_pkg::PH_HEADER;
        end
      end
    endcase

    unique case (act)
      tcrd_pkg::ACT_FAIL, tcrd_pkg::ACT_END_ONLY: begin
        phase_next = last ? tcrd_pkg::PH_HEADER : tcrd_pkg::PH_SKIP;
      end
      tcrd_pkg::ACT_COL_END: begin
        if (final_col) begin
          phase_next = last ? tcrd_pkg::PH_HEADER : tcrd_pkg::PH_SKIP;
        end else begin
          current_column_next = current_column + 8'd1;
          phase_next          = tcrd_pkg::PH_TAG;
        end
      end
      tcrd_pkg::ACT_LENGTH: begin
        payload_bytes_left_next = len_value[PAYLOAD_LENGTH_BITS-1:0];
        phase_next              = tcrd_pkg::PH_PAYLOAD;
      end
      default: begin
        phase_next = phase_next;
      end
    endcase
  end

  // result fields
  always_comb begin
    res_kind    = tcrd_pkg::KIND_ERROR;
    res_column  = (phase == tcrd_pkg::PH_HEADER) ? 8'd0 : current_column;
    res_value   = '0;
    res_payload = '0;
    res_done    = 1'b0;
    res_err     = tcrd_pkg::ERR_NONE;
    res_count   = columns_total;
    unique case (act)
      tcrd_pkg::ACT_FAIL: begin
        res_kind  = tcrd_pkg::KIND_ERROR;
        res_done  = 1'b1;
        res_err   = act_err;
        res_count = '0;
      end
      tcrd_pkg::ACT_END_ONLY: begin
        res_kind   = tcrd_pkg::KIND_END;
        res_column = '0;
        res_done   = 1'b1;
        res_count  = '0;
      end
      tcrd_pkg::ACT_COL_END: begin
        res_kind    = col_kind;
        res_value   = col_value;
        res_payload = (col_kind == tcrd_pkg::KIND_PAYLOAD) ? b : 8'd0;
        res_done    = final_col;
      end
      tcrd_pkg::ACT_LENGTH: begin
        res_kind  = len_kind;
        res_value = len_value;
      end
      tcrd_pkg::ACT_PAYLOAD: begin
        res_kind    = tcrd_pkg::KIND_PAYLOAD;
        res_payload = b;
      end
      default: begin
        res_kind = tcrd_pkg::KIND_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= tcrd_pkg::PH_HEADER;
      columns_total      <= '0;
      current_column     <= '0;
      current_type       <= '0;
      field_bytes_left   <= '0;
      byte_position      <= '0;
      value_accumulator  <= '0;
      payload_bytes_left <= '0;
    end else if (q_pop) begin
      phase              <= phase_next;
      columns_total      <= columns_total_next;
      current_column     <= current_column_next;
      current_type       <= current_type_next;
      field_bytes_left   <= field_bytes_left_next;
      byte_position      <= byte_position_next;
      value_accumulator  <= value_accumulator_next;
      payload_bytes_left <= payload_bytes_left_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= (act != tcrd_pkg::ACT_NONE);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind          <= '0;
      column_index  <= '0;
      value_bits    <= '0;
      payload_value <= '0;
      record_done   <= 1'b0;
      error_code    <= '0;
      column_count  <= '0;
    end else if (q_pop) begin
      kind          <= res_kind;
      column_index  <= res_column;
      value_bits    <= res_value;
      payload_value <= res_payload;
      record_done   <= res_done;
      error_code    <= res_err;
      column_count  <= res_count;
    end
  end

endmodule

// ----- hw/rtl/typed_column_record_decoder.sv -----
// ----------------------------------------------------------------------------
// typed_column_record_decoder
// decodes packed typed column records, one byte per transfer
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry data_byte and last_byte; last_byte
// marks the final byte of a record. The first byte is the column count, then
// each column is a tag byte followed by its field and payload bytes.
// Output channel: out_valid/out_ready carry one result per column, per
// length field and per payload byte, plus end-only and error results.
// A byte accepted on the input is written into the queue, then taken by the
// parser, whose output register raises out_valid with its result (if any);
// bytes that only fill a field give no result.
// Throughput is one byte per cycle while the output is not stalled. A
// four-entry queue sits between the byte classifier and the parser, so
// input keeps flowing while out_ready is low until the queue is full;
// after that in_ready drops until the parser moves again.
// Reset (rst, synchronous) empties the queue, drops out_valid and puts the
// parser back to waiting for a header byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module typed_column_record_decoder #(
  parameter int PAYLOAD_LENGTH_BITS = tcrd_pkg::PAYLOAD_LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  column_index,
  output logic [63:0] value_bits,
  output logic [7:0]  payload_value,
  output logic        record_done,
  output logic [1:0]  error_code,
  output logic [7:0]  column_count
);

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  tcrd_pkg::entry_t  push_entry;
  tcrd_pkg::entry_t  head_entry;

  tcrd_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  tcrd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  tcrd_back #(
    .PAYLOAD_LENGTH_BITS (PAYLOAD_LENGTH_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_entry       (head_entry),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .column_index  (column_index),
    .value_bits    (value_bits),
    .payload_value (payload_value),
    .record_done   (record_done),
    .error_code    (error_code),
    .column_count  (column_count)
  );

endmodule

// ----- hw/rtl/tcrd_checker.sv -----
// ----------------------------------------------------------------------------
// tcrd_checker
// port-level checks on the record decoder results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "typed_column_record_decoder_defines.svh"

module tcrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic [7:0]  column_index,
  input logic [63:0] value_bits,
  input logic [7:0]  payload_value,
  input logic        record_done,
  input logic [1:0]  error_code,
  input logic [7:0]  column_count
);

  // a stalled result holds its payload
  `TCRD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(kind) && $stable(value_bits) && $stable(column_index) &&
    $stable(payload_value) && $stable(record_done) && $stable(error_code))

  // errors end the record, carry a code and no count
  `TCRD_ASSERT_NOW(a_error_shape, clk, rst, out_valid && kind == tcrd_pkg::KIND_ERROR,
    record_done && error_code != tcrd_pkg::ERR_NONE && column_count == 8'd0 &&
    value_bits == 64'd0)

  // only errors carry an error code
  `TCRD_ASSERT_NOW(a_code_only_on_error, clk, rst,
    out_valid && kind != tcrd_pkg::KIND_ERROR, error_code == tcrd_pkg::ERR_NONE)

  // end-only result of an empty record
  `TCRD_ASSERT_NOW(a_end_only_shape, clk, rst, out_valid && kind == tcrd_pkg::KIND_END,
    record_done && column_index == 8'd0 && column_count == 8'd0 &&
    payload_value == 8'd0)

endmodule

bind typed_column_record_decoder tcrd_checker u_tcrd_checker (.*);

// ----- dv/typed_column_record_checker.sv -----
// ----------------------------------------------------------------------------
// typed_column_record_checker
// predicts the results of the record decoder and compares them as they leave
// ----------------------------------------------------------------------------
// Watches both channels of the decoder. Every byte transfer on the input side
// runs through a cycle-free copy of the parser, which queues the result that
// byte should cause. Every result transfer is compared field by field with
// the oldest queued result. Handshakes are sampled on the falling edge, where
// all signals are settled, and stand for the transfer at the next rising edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module typed_column_record_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  kind,
  input  logic [7:0]  column_index,
  input  logic [63:0] value_bits,
  input  logic [7:0]  payload_value,
  input  logic        record_done,
  input  logic [1:0]  error_code,
  input  logic [7:0]  column_count,
  output int          fail_count,
  output int          pending,
  output int          results_checked,
  output int          error_results
);

  localparam int PLB = tcrd_pkg::PAYLOAD_LENGTH_BITS_DEF;
  localparam logic [63:0] PAYLOAD_LIMIT = (64'd1 << PLB) - 64'd1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  col;
    logic [63:0] value;
    logic [7:0]  payload;
    logic        done;
    logic [1:0]  err;
    logic [7:0]  count;
  } decoded_t;

  decoded_t column_results_due[$];

  // parser copy
  tcrd_pkg::phase_t  phase;
  logic [7:0]        col_total;
  logic [7:0]        cur_col;
  logic [2:0]        col_type;
  logic [3:0]        field_left;
  logic [2:0]        byte_pos;
  logic [63:0]       field_acc;
  logic [PLB-1:0]    payload_left;

  task automatic clear_parser();
    phase        = tcrd_pkg::PH_HEADER;
    col_total    = '0;
    cur_col      = '0;
    col_type     = '0;
    field_left   = '0;
    byte_pos     = '0;
    field_acc    = '0;
    payload_left = '0;
    column_results_due.delete();
  endtask

  task automatic emit_result(input logic [2:0] k, input logic [7:0] col,
                             input logic [63:0] val, input logic [7:0] pay,
                             input logic done, input logic [1:0] err,
                             input logic [7:0] cnt);
    column_results_due.push_back({k, col, val, pay, done, err, cnt});
  endtask

  // after a record ends, either wait for a header or drop bytes until last
  task automatic close_record(input logic last);
    if (last) begin
      phase = tcrd_pkg::PH_HEADER;
    end else begin
      phase = tcrd_pkg::PH_SKIP;
    end
  endtask

  task automatic abort_record(input logic [1:0] err, input logic last);
    emit_result(tcrd_pkg::KIND_ERROR, cur_col, 64'd0, 8'd0, 1'b1, err, 8'd0);
    close_record(last);
  endtask

  task automatic finish_column(input logic [2:0] k, input logic [63:0] val,
                               input logic [7:0] pay, input logic last);
    logic last_col;
    last_col = ({1'b0, cur_col} + 9'd1) >= {1'b0, col_total};
    if (!last_col && last) begin
      abort_record(tcrd_pkg::ERR_TRUNCATED, last);
    end else begin
      emit_result(k, cur_col, val, pay, last_col, tcrd_pkg::ERR_NONE, col_total);
      if (last_col) begin
        close_record(last);
      end else begin
        cur_col = cur_col + 8'd1;
        phase   = tcrd_pkg::PH_TAG;
      end
    end
  endtask

  task automatic finish_length(input logic [63:0] len, input logic last);
    logic [2:0] k;
    k = (col_type == tcrd_pkg::TYPE_BLOB) ? tcrd_pkg::KIND_BLOB_LEN
                                          : tcrd_pkg::KIND_TEXT_LEN;
    if (len > PAYLOAD_LIMIT) begin
      abort_record(tcrd_pkg::ERR_OVERSIZE, last);
    end else if (len == 64'd0) begin
      finish_column(k, 64'd0, 8'd0, last);
    end else if (last) begin
      abort_record(tcrd_pkg::ERR_TRUNCATED, last);
    end else begin
      emit_result(k, cur_col, len, 8'd0, 1'b0, tcrd_pkg::ERR_NONE, col_total);
      payload_left = len[PLB-1:0];
      phase        = tcrd_pkg::PH_PAYLOAD;
    end
  endtask

  task automatic open_field(input logic [3:0] nbytes, input logic last);
    if (last) begin
      abort_record(tcrd_pkg::ERR_TRUNCATED, last);
    end else begin
      field_left = nbytes;
      byte_pos   = '0;
      field_acc  = '0;
      phase      = tcrd_pkg::PH_FIELD;
    end
  endtask

  task automatic decode_record_byte(input logic [7:0] b, input logic last);
    logic [2:0] t;
    logic [4:0] n;
    t = b[2:0];
    n = b[7:3];
    case (phase)
      tcrd_pkg::PH_TAG: begin
        col_type = t;
        if (t == tcrd_pkg::TYPE_NULL) begin
          finish_column(tcrd_pkg::KIND_NULL, 64'd0, 8'd0, last);
        end else if (t == tcrd_pkg::TYPE_INTEGER) begin
          if (n > 5'd8) begin
            abort_record(tcrd_pkg::ERR_OVERSIZE, last);
          end else if (n == 5'd0) begin
            finish_column(tcrd_pkg::KIND_INTEGER, 64'd0, 8'd0, last);
          end else begin
            open_field(n[3:0], last);
          end
        end else if (t == tcrd_pkg::TYPE_FLOAT) begin
          // count bits of a float tag do not matter
          open_field(tcrd_pkg::FLOAT_BYTES, last);
        end else if (t == tcrd_pkg::TYPE_TEXT || t == tcrd_pkg::TYPE_BLOB) begin
          if (n > 5'd4) begin
            abort_record(tcrd_pkg::ERR_OVERSIZE, last);
          end else if (n == 5'd0) begin
            finish_length(64'd0, last);
          end else begin
            open_field(n[3:0], last);
          end
        end else begin
          abort_record(tcrd_pkg::ERR_UNKNOWN, last);
        end
      end
      tcrd_pkg::PH_FIELD: begin
        field_acc  = field_acc | ({56'd0, b} << {byte_pos, 3'b000});
        byte_pos   = byte_pos + 3'd1;
        field_left = field_left - 4'd1;
        if (field_left != 4'd0) begin
          if (last) begin
            abort_record(tcrd_pkg::ERR_TRUNCATED, last);
          end
        end else if (col_type == tcrd_pkg::TYPE_TEXT ||
                     col_type == tcrd_pkg::TYPE_BLOB) begin
          finish_length(field_acc, last);
        end else begin
          finish_column((col_type == tcrd_pkg::TYPE_FLOAT) ? tcrd_pkg::KIND_FLOAT
                                                           : tcrd_pkg::KIND_INTEGER,
                        field_acc, 8'd0, last);
        end
      end
      tcrd_pkg::PH_PAYLOAD: begin
        payload_left = payload_left - 1'b1;
        if (payload_left != '0) begin
          if (last) begin
            abort_record(tcrd_pkg::ERR_TRUNCATED, last);
          end else begin
            emit_result(tcrd_pkg::KIND_PAYLOAD, cur_col, 64'd0, b, 1'b0,
                        tcrd_pkg::ERR_NONE, col_total);
          end
        end else begin
          finish_column(tcrd_pkg::KIND_PAYLOAD, 64'd0, b, last);
        end
      end
      tcrd_pkg::PH_SKIP: begin
        if (last) begin
          phase = tcrd_pkg::PH_HEADER;
        end
      end
      default: begin
        col_total = b;
        cur_col   = '0;
        if (b == 8'd0) begin
          emit_result(tcrd_pkg::KIND_END, 8'd0, 64'd0, 8'd0, 1'b1,
                      tcrd_pkg::ERR_NONE, 8'd0);
          close_record(last);
        end else if (last) begin
          abort_record(tcrd_pkg::ERR_TRUNCATED, last);
        end else begin
          phase = tcrd_pkg::PH_TAG;
        end
      end
    endcase
  endtask

  task automatic flag_field(input string what, input logic [63:0] want_v,
                            input logic [63:0] got_v);
    fail_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
  endtask

  task automatic compare_result(input decoded_t want, input decoded_t got);
    if (got.kind !== want.kind) begin
      flag_field("kind", 64'(want.kind), 64'(got.kind));
    end
    if (got.col !== want.col) begin
      flag_field("column_index", 64'(want.col), 64'(got.col));
    end
    if (got.value !== want.value) begin
      flag_field("value_bits", want.value, got.value);
    end
    if (got.payload !== want.payload) begin
      flag_field("payload_value", 64'(want.payload), 64'(got.payload));
    end
    if (got.done !== want.done) begin
      flag_field("record_done", 64'(want.done), 64'(got.done));
    end
    if (got.err !== want.err) begin
      flag_field("error_code", 64'(want.err), 64'(got.err));
    end
    if (got.count !== want.count) begin
      flag_field("column_count", 64'(want.count), 64'(got.count));
    end
  endtask

  always @(negedge clk) begin : watch
    decoded_t got;
    if (rst) begin
      clear_parser();
      fail_count      = 0;
      results_checked = 0;
      error_results   = 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_record_byte(data_byte, last_byte);
      end
      if (out_valid && out_ready) begin
        got = {kind, column_index, value_bits, payload_value, record_done,
               error_code, column_count};
        results_checked++;
        if (got.kind == tcrd_pkg::KIND_ERROR) begin
          error_results++;
        end
        if (column_results_due.size() == 0) begin
          fail_count++;
          $display("%0t: result transfer, expected none, actual kind %0h column %0d",
                   $time, got.kind, got.col);
        end else begin
          compare_result(column_results_due.pop_front(), got);
        end
      end
    end
    pending = column_results_due.size();
  end

endmodule

// ----- dv/tb_typed_column_record_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_typed_column_record_decoder
// regression bench for the typed column record decoder
// ----------------------------------------------------------------------------
// Feeds a directed set of records covering every column type, the zero-column
// header, truncation, unknown and oversized tags and trailing bytes, then
// random records: mostly well-formed with random content, the rest cut short,
// broken by a bad column, or plain noise. Both channels stall at random. The
// checker beside the decoder predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_typed_column_record_decoder;

  localparam int TOTAL_BYTES = 1750;
  localparam int IDLE_PCT    = 22;

  // tag types with no meaning
  localparam logic [2:0] TYPE_UNDEF0 = 3'd0;
  localparam logic [2:0] TYPE_UNDEF6 = 3'd6;
  localparam logic [2:0] TYPE_UNDEF7 = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  column_index;
  logic [63:0] value_bits;
  logic [7:0]  payload_value;
  logic        record_done;
  logic [1:0]  error_code;
  logic [7:0]  column_count;

  int fail_count;
  int pending;
  int results_checked;
  int error_results;

  logic       calm = 1'b0;
  logic [7:0] rec_q[$];
  int         bytes_sent = 0;
  int         records_sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typed_column_record_decoder uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .column_index (column_index),
    .value_bits   (value_bits),
    .payload_value(payload_value),
    .record_done  (record_done),
    .error_code   (error_code),
    .column_count (column_count)
  );

  typed_column_record_checker chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .column_index   (column_index),
    .value_bits     (value_bits),
    .payload_value  (payload_value),
    .record_done    (record_done),
    .error_code     (error_code),
    .column_count   (column_count),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked),
    .error_results  (error_results)
  );

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // record assembly

  function automatic void put_byte(input logic [7:0] b);
    rec_q.push_back(b);
  endfunction

  // little-endian field of nbytes bytes, zero beyond the eighth byte
  function automatic void put_field(input int nbytes, input logic [63:0] val);
    for (int i = 0; i < nbytes; i++) begin
      put_byte((i < 8) ? val[8*i +: 8] : 8'd0);
    end
  endfunction

  function automatic void put_int(input logic [4:0] nbytes, input logic [63:0] val);
    put_byte({nbytes, tcrd_pkg::TYPE_INTEGER});
    put_field(int'(nbytes), val);
  endfunction

  function automatic void put_column();
    logic [4:0]  n;
    logic [2:0]  t;
    logic [63:0] val;
    int          len;
    val = {$urandom, $urandom};
    case ($urandom_range(7))
      0: val = '1;
      1: val = '0;
      default: ;
    endcase
    case ($urandom_range(3))
      0: put_byte({5'($urandom), tcrd_pkg::TYPE_NULL});
      1: put_int(5'($urandom_range(8)), val);
      2: begin
        put_byte({5'($urandom), tcrd_pkg::TYPE_FLOAT});
        put_field(8, val);
      end
      default: begin
        t = $urandom_range(1) ? tcrd_pkg::TYPE_TEXT : tcrd_pkg::TYPE_BLOB;
        n = 5'($urandom_range(4));
        if (n == 5'd0) begin
          len = 0;
        end else if ($urandom_range(9) == 0) begin
          len = $urandom_range(40, 7);
        end else begin
          len = $urandom_range(6);
        end
        put_byte({n, t});
        put_field(int'(n), 64'(len));
        repeat (len) put_byte(8'($urandom));
      end
    endcase
  endfunction

  function automatic void put_bad_column();
    logic [2:0] t;
    t = $urandom_range(1) ? tcrd_pkg::TYPE_TEXT : tcrd_pkg::TYPE_BLOB;
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(2))
          0: put_byte({5'($urandom), TYPE_UNDEF0});
          1: put_byte({5'($urandom), TYPE_UNDEF6});
          default: put_byte({5'($urandom), TYPE_UNDEF7});
        endcase
      end
      1: put_byte({5'($urandom_range(31, 9)), tcrd_pkg::TYPE_INTEGER});
      2: put_byte({5'($urandom_range(31, 5)), t});
      default: begin
        // length beyond the payload limit
        put_byte({5'd4, t});
        put_field(4, {32'd0, 1'b1, 31'($urandom)});
      end
    endcase
  endfunction

  function automatic void put_junk(input int count);
    repeat (count) put_byte(8'($urandom));
  endfunction

  function automatic int pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 6) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(5, 1);
    end
    return $urandom_range(24, 6);
  endfunction

  // transfer

  task automatic send_byte(input logic [7:0] b, input logic last);
    logic took;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end
    bytes_sent++;
  endtask

  // sends the first nbytes of the assembled record, flagging the last one
  task automatic send_record(input int nbytes);
    for (int i = 0; i < nbytes; i++) begin
      send_byte(rec_q[i], i == nbytes - 1);
    end
    rec_q.delete();
    records_sent++;
  endtask

  initial begin : stimulus
    int ncols;
    int good;
    int sel;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // zero columns
    put_byte(8'd0);
    send_record(rec_q.size());
    // null with count bits set, empty integer, empty text
    put_byte(8'd3);
    put_byte({5'h1F, tcrd_pkg::TYPE_NULL});
    put_int(5'd0, 64'd0);
    put_byte({5'd0, tcrd_pkg::TYPE_TEXT});
    send_record(rec_q.size());
    // float of all ones, blob with two payload bytes
    put_byte(8'd2);
    put_byte({5'h1F, tcrd_pkg::TYPE_FLOAT});
    put_field(8, '1);
    put_byte({5'd1, tcrd_pkg::TYPE_BLOB});
    put_byte(8'd2);
    put_byte(8'h00);
    put_byte(8'hFF);
    send_record(rec_q.size());
    // oversized integer, then skipped bytes
    put_byte(8'd1);
    put_int(5'd9, 64'd0);
    put_byte(8'h5A);
    send_record(rec_q.size());
    // unknown type on the final byte
    put_byte(8'd1);
    put_byte({5'd0, TYPE_UNDEF7});
    send_record(rec_q.size());
    // oversized length field beats truncation
    put_byte(8'd2);
    put_byte({5'd5, tcrd_pkg::TYPE_TEXT});
    send_record(rec_q.size());
    // length too large for a payload
    put_byte(8'd1);
    put_byte({5'd4, tcrd_pkg::TYPE_BLOB});
    put_field(4, 64'hFFFF_FFFF);
    send_record(rec_q.size());
    // header cut short
    put_byte(8'd2);
    send_record(rec_q.size());
    // record complete before its last flag, trailing bytes follow
    put_byte(8'd1);
    put_int(5'd1, 64'h80);
    put_byte(8'h55);
    put_byte(8'hAA);
    send_record(rec_q.size());

    // widest record: 255 columns, so column index runs up to 254
    put_byte(8'd255);
    repeat (255) begin
      if ($urandom_range(1)) begin
        put_byte({5'($urandom), tcrd_pkg::TYPE_NULL});
      end else begin
        put_int(5'd0, 64'd0);
      end
    end
    send_record(rec_q.size());

    while (bytes_sent < TOTAL_BYTES) begin
      calm <= (records_sent >= 60 && records_sent < 100);
      sel = $urandom_range(99);
      if (sel < 68) begin
        ncols = pick_count();
        put_byte(8'(ncols));
        repeat (ncols) put_column();
        if ($urandom_range(3) == 0) begin
          put_junk($urandom_range(3, 1));
        end
        send_record(rec_q.size());
      end else if (sel < 83) begin
        ncols = $urandom_range(5, 1);
        put_byte(8'(ncols));
        repeat (ncols) put_column();
        send_record($urandom_range(rec_q.size() - 1, 1));
      end else if (sel < 94) begin
        ncols = $urandom_range(5, 1);
        good = $urandom_range(ncols - 1);
        put_byte(8'(ncols));
        repeat (good) put_column();
        put_bad_column();
        if ($urandom_range(2) != 0) begin
          put_junk($urandom_range(4, 1));
        end
        send_record(rec_q.size());
      end else begin
        put_junk($urandom_range(8, 1));
        send_record(rec_q.size());
      end
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d bytes in %0d records; %0d results checked, %0d of them errors",
             bytes_sent, records_sent, results_checked, error_results);
    if (fail_count == 0) begin
      $display("typed_column_record_decoder regression: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("typed_column_record_decoder regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("typed_column_record_decoder regression: fail");
    $finish;
  end

endmodule
